>>> sv/rrq_pkg.sv
// rrq_pkg: operation and status codes shared by the round-robin ready queue.
// No dependencies.
package rrq_pkg;

  localparam int ID_W    = 4;
  localparam int NUM_IDS = 1 << ID_W;
  localparam int LEN_W   = ID_W + 1;

  typedef logic [ID_W-1:0]    task_id_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [NUM_IDS-1:0] id_mask_t;
  typedef logic [1:0]         mode_t;
  typedef logic [1:0]         status_t;

  localparam mode_t MODE_ADD    = 2'd0;
  localparam mode_t MODE_REMOVE = 2'd1;
  localparam mode_t MODE_SCHED  = 2'd2;
  localparam mode_t MODE_MARK   = 2'd3;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_NOTFOUND = 2'd1;
  localparam status_t STATUS_EMPTY    = 2'd2;

endpackage

>>> sv/round_robin_ready_queue.sv
// round_robin_ready_queue: ready queue of task ids kept as a doubly linked list.
// Depends on rrq_pkg and rrq_ram.
//
// Usage: drive mode, task_id, current_id and current_valid with start high;
// the request is taken at a rising edge where start is high and busy is low.
// The queue is a doubly linked list indexed by task id: one RAM holds the
// successor of each queued task, another its predecessor. Head, tail, count
// and the queued/terminated masks live in flops.
// Latency: the RAMs are read at the accept edge, the following cycle does the
// update and write-back, and the result is on the outputs with done high for
// exactly one cycle after that. busy is high in that one update cycle only,
// so a new request may be taken while done is high: 2 cycles per request,
// set by the one-cycle read latency of the link RAMs.
// The receiver cannot stall; results are valid only while done is high.
// Reset (rst, synchronous) empties the queue and clears all marks and the
// switch counter; no clearing pass is needed since a link entry is read only
// after it was written.
module round_robin_ready_queue
  import rrq_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     mode,
  input  logic [3:0]     task_id,
  input  logic [3:0]     current_id,
  input  logic           current_valid,
  output logic           done,
  output logic [3:0]     chosen_id,
  output logic           chosen_valid,
  output logic           switched,
  output logic [1:0]     status,
  output logic [4:0]     queue_length,
  output logic [31:0]    switch_count
);

  localparam int   QUEUE_CAP = (MAX_TASKS < NUM_IDS) ? MAX_TASKS : NUM_IDS;
  localparam len_t CAP_LEN   = LEN_W'(QUEUE_CAP);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic     state;
  mode_t    op_mode;
  task_id_t op_task, op_cur;
  logic     op_cur_valid;

  task_id_t head, tail;
  len_t     count;
  id_mask_t queued, terminated;
  logic [31:0] counter;

  task_id_t head_next, tail_next;
  len_t     count_next;
  id_mask_t queued_next, terminated_next;
  logic [31:0] counter_next;

  task_id_t res_id;
  logic     res_valid, res_switched;
  status_t  res_status;

  logic     accept;
  task_id_t rd_addr, nxt_rdata, prv_rdata;
  logic     nxt_we, prv_we;
  task_id_t nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;
  assign rd_addr = (mode == MODE_SCHED) ? head : task_id;

  rrq_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(rd_addr), .rdata(nxt_rdata)
  );

  rrq_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(rd_addr), .rdata(prv_rdata)
  );

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    queued_next     = queued;
    terminated_next = terminated;
    counter_next    = counter;
    res_id          = '0;
    res_valid       = 1'b0;
    res_switched    = 1'b0;
    res_status      = STATUS_OK;
    nxt_we          = 1'b0;
    nxt_waddr       = tail;
    nxt_wdata       = op_task;
    prv_we          = 1'b0;
    prv_waddr       = op_task;
    prv_wdata       = tail;
    if (state == ST_EXEC) begin
      case (op_mode)
        MODE_ADD: begin
          if (queued[op_task] || count >= CAP_LEN) begin
            res_status = STATUS_NOTFOUND;
          end else begin
            terminated_next[op_task] = 1'b0;
            queued_next[op_task]     = 1'b1;
            count_next               = count + LEN_W'(1);
            tail_next                = op_task;
            if (count == '0) begin
              head_next = op_task;
            end else begin
              nxt_we = 1'b1;
              prv_we = 1'b1;
            end
          end
        end
        MODE_REMOVE: begin
          if (!queued[op_task]) begin
            res_status = STATUS_NOTFOUND;
          end else begin
            queued_next[op_task] = 1'b0;
            count_next           = count - LEN_W'(1);
            if (op_task == head) begin
              head_next = nxt_rdata;
            end else begin
              nxt_we    = 1'b1;
              nxt_waddr = prv_rdata;
              nxt_wdata = nxt_rdata;
            end
            if (op_task == tail) begin
              tail_next = prv_rdata;
            end else begin
              prv_we    = 1'b1;
              prv_waddr = nxt_rdata;
              prv_wdata = prv_rdata;
            end
          end
        end
        MODE_SCHED: begin
          if (count == '0) begin
            res_status = STATUS_EMPTY;
          end else begin
            res_id       = head;
            res_valid    = 1'b1;
            res_switched = !op_cur_valid || (op_cur != head);
            if (res_switched) begin
              counter_next = counter + 32'd1;
            end
            if (terminated[head]) begin
              queued_next[head] = 1'b0;
              count_next        = count - LEN_W'(1);
              head_next         = nxt_rdata;
            end else if (count != LEN_W'(1)) begin
              head_next = nxt_rdata;
              tail_next = head;
              nxt_we    = 1'b1;
              nxt_wdata = head;
              prv_we    = 1'b1;
              prv_waddr = head;
            end
          end
        end
        MODE_MARK: begin
          terminated_next[op_task] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      queued     <= '0;
      terminated <= '0;
      counter    <= '0;
    end else begin
      done <= (state == ST_EXEC);
      if (accept) begin
        state <= ST_EXEC;
      end else begin
        state <= ST_IDLE;
      end
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      queued     <= queued_next;
      terminated <= terminated_next;
      counter    <= counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode      <= mode;
      op_task      <= task_id;
      op_cur       <= current_id;
      op_cur_valid <= current_valid;
    end
    if (state == ST_EXEC) begin
      chosen_id    <= res_id;
      chosen_valid <= res_valid;
      switched     <= res_switched;
      status       <= res_status;
      queue_length <= count_next;
      switch_count <= counter_next;
    end
  end

  // list length always matches the queued mask
  assert property (@(posedge clk) disable iff (rst)
    $countones(queued) == 32'(count))
    else $error("queue count does not match queued mask");

  assert property (@(posedge clk) disable iff (rst)
    count <= CAP_LEN)
    else $error("queue count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("request did not complete in one update cycle");

  assert property (@(posedge clk) disable iff (rst)
    done && chosen_valid |-> status == STATUS_OK)
    else $error("schedule result inconsistent");

  assert property (@(posedge clk) disable iff (rst)
    done && !chosen_valid |-> chosen_id == '0 && !switched)
    else $error("unexpected pick without schedule");

endmodule

>>> sv/rrq_ram.sv
// rrq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
